[hdl/gds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gds_pkg: shared types and constants for the grid DFS step core
// Grid geometry, stack sizing, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package gds_pkg;

	localparam int StackDepth = 16;
	localparam int CntW       = $clog2(StackDepth + 1);
	localparam int IdxW       = $clog2(StackDepth);
	localparam int SlotW      = CntW + 1;

	localparam int GridCells  = 64;
	localparam int CellW      = 6;
	localparam int CoordW     = 3;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 32;

	localparam logic [CoordW-1:0] ResetStartRow = 3'd2;
	localparam logic [CoordW-1:0] ResetStartCol = 3'd3;
	localparam logic [CellW-1:0]  ResetGoal     = 6'd54;
	localparam logic [31:0]       ResetBlkLow   = 32'h7007_B600;
	localparam logic [31:0]       ResetBlkHigh  = 32'hE00E_D07E;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_START_ROW    = 3'd0,
		CFG_START_COL    = 3'd1,
		CFG_GOAL_CELL    = 3'd2,
		CFG_BLOCKED_LOW  = 3'd3,
		CFG_BLOCKED_HIGH = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_MOVED   = 2'd0,
		ST_AT_GOAL = 2'd1,
		ST_STUCK   = 2'd2,
		ST_RESTART = 2'd3
	} status_t;

	typedef struct packed {
		logic              dropped;
		status_t           status;
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
	} result_t;

endpackage
`default_nettype wire

[hdl/grid_dfs_step_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_dfs_step_core: one depth-first search step per transfer on an 8x8 grid
//
// Input stream: s_tdata[0] = restart. A restart clears the visited map and the
// stack and moves to the start cell; otherwise one search step is taken: check
// the goal, push the free neighbors (col+1, row+1, col-1, row-1), pop the top.
// Output stream: one result per input transfer, with the position after the
// step, push_dropped in tdata and the status code in tuser.
// Configuration: cfg_we/cfg_index/cfg_data write start row/col, goal cell and
// the two wall words; write only while the block is idle.
// Throughput: one item per cycle while s_tready is high; neighbor checks,
// pushes and the pop all fit in one pass between the search state registers
// and the output register. When the receiver stalls, a second result is
// caught in a skid register and s_tready drops only while that skid
// register is occupied.
// Reset: position goes to the reset start cell with only its visited bit set,
// the stack is empty, the registers take their reset values and no result
// is pending.
// ----------------------------------------------------------------------------
module grid_dfs_step_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] restart
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [2:0] cur_row, [5:3] cur_col, [6] push_dropped
	output logic [1:0]       m_tuser,   // [1:0] status
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [gds_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [gds_pkg::CfgDataW-1:0] cfg_data
);

	localparam int CntW  = gds_pkg::CntW;
	localparam int IdxW  = gds_pkg::IdxW;
	localparam int SlotW = gds_pkg::SlotW;
	localparam int CellW = gds_pkg::CellW;

	// configuration registers
	logic [2:0]  start_row_q, start_col_q;
	logic [5:0]  goal_q;
	logic [31:0] blk_low_q, blk_high_q;

	// search state
	logic [2:0]          pos_row_q, pos_col_q;
	logic [63:0]         visited_q;
	logic [CntW-1:0]     count_q;
	logic [CellW-1:0]    stack_q [gds_pkg::StackDepth];

	// output register and skid register
	gds_pkg::result_t    out_q, skid_q;
	logic                out_v_q, skid_v_q;

	// step logic
	logic [63:0]         walls;
	logic [CellW-1:0]    nb_cell [4];
	logic [3:0]          nb_in, nb_free, nb_acc;
	logic [SlotW-1:0]    nb_slot [4];
	logic [SlotW-1:0]    rank;
	logic [CntW-1:0]     push_cnt;
	logic                any_acc, dropped, at_goal, restart;
	logic [CellW-1:0]    last_cell, top_cell, pop_cell;
	logic [63:0]         visited_nxt;
	logic [CntW-1:0]     count_nxt;
	logic [2:0]          row_nxt, col_nxt;
	gds_pkg::status_t    status_nxt;
	gds_pkg::result_t    res;
	logic                step_go, acc, drain;

	assign walls   = {blk_high_q, blk_low_q};
	assign restart = s_tdata[0];
	assign at_goal = ({pos_row_q, pos_col_q} == goal_q);

	assign s_tready = !skid_v_q;
	assign acc      = s_tvalid && s_tready;
	assign drain    = out_v_q && m_tready;
	assign step_go  = acc && !restart && !at_goal;

	// neighbor checks and stack slot assignment
	always_comb begin
		nb_cell[0] = {pos_row_q, pos_col_q + 3'd1};
		nb_cell[1] = {pos_row_q + 3'd1, pos_col_q};
		nb_cell[2] = {pos_row_q, pos_col_q - 3'd1};
		nb_cell[3] = {pos_row_q - 3'd1, pos_col_q};
		nb_in[0]   = (pos_col_q != 3'd7);
		nb_in[1]   = (pos_row_q != 3'd7);
		nb_in[2]   = (pos_col_q != 3'd0);
		nb_in[3]   = (pos_row_q != 3'd0);

		rank        = '0;
		push_cnt    = '0;
		dropped     = 1'b0;
		any_acc     = 1'b0;
		last_cell   = '0;
		visited_nxt = visited_q;
		for (int i = 0; i < 4; i++) begin
			nb_free[i] = nb_in[i] && !visited_q[nb_cell[i]] && !walls[nb_cell[i]];
			nb_slot[i] = SlotW'(count_q) + rank;
			nb_acc[i]  = nb_free[i] && (nb_slot[i] < SlotW'(gds_pkg::StackDepth));
			if (nb_free[i]) begin
				rank = rank + SlotW'(1);
				visited_nxt[nb_cell[i]] = 1'b1;
			end
			if (nb_free[i] && !nb_acc[i]) begin
				dropped = 1'b1;
			end
			if (nb_acc[i]) begin
				push_cnt  = push_cnt + CntW'(1);
				any_acc   = 1'b1;
				last_cell = nb_cell[i];
			end
		end
	end

	// pop: the last accepted push comes straight back, else the old top
	assign top_cell = stack_q[IdxW'(count_q - CntW'(1))];
	assign pop_cell = any_acc ? last_cell : top_cell;

	always_comb begin
		row_nxt    = pos_row_q;
		col_nxt    = pos_col_q;
		count_nxt  = count_q;
		status_nxt = gds_pkg::ST_STUCK;
		if (restart) begin
			row_nxt    = start_row_q;
			col_nxt    = start_col_q;
			count_nxt  = '0;
			status_nxt = gds_pkg::ST_RESTART;
		end else if (at_goal) begin
			status_nxt = gds_pkg::ST_AT_GOAL;
		end else if (any_acc || count_q != '0) begin
			row_nxt    = pop_cell[5:3];
			col_nxt    = pop_cell[2:0];
			count_nxt  = count_q + push_cnt - CntW'(1);
			status_nxt = gds_pkg::ST_MOVED;
		end
		res.row     = row_nxt;
		res.col     = col_nxt;
		res.status  = status_nxt;
		res.dropped = !restart && !at_goal && dropped;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= gds_pkg::ResetStartRow;
			start_col_q <= gds_pkg::ResetStartCol;
			goal_q      <= gds_pkg::ResetGoal;
			blk_low_q   <= gds_pkg::ResetBlkLow;
			blk_high_q  <= gds_pkg::ResetBlkHigh;
		end else if (cfg_we) begin
			case (cfg_index)
				gds_pkg::CFG_START_ROW:    start_row_q <= cfg_data[2:0];
				gds_pkg::CFG_START_COL:    start_col_q <= cfg_data[2:0];
				gds_pkg::CFG_GOAL_CELL:    goal_q      <= cfg_data[5:0];
				gds_pkg::CFG_BLOCKED_LOW:  blk_low_q   <= cfg_data;
				gds_pkg::CFG_BLOCKED_HIGH: blk_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q <= gds_pkg::ResetStartRow;
			pos_col_q <= gds_pkg::ResetStartCol;
			visited_q <= 64'(1) << {gds_pkg::ResetStartRow, gds_pkg::ResetStartCol};
			count_q   <= '0;
		end else if (acc) begin
			pos_row_q <= row_nxt;
			pos_col_q <= col_nxt;
			count_q   <= count_nxt;
			if (restart) begin
				visited_q <= 64'(1) << {start_row_q, start_col_q};
			end else if (!at_goal) begin
				visited_q <= visited_nxt;
			end
		end
	end

	// stack entries need no reset; write every accepted push
	always_ff @(posedge clk) begin
		if (step_go) begin
			for (int i = 0; i < 4; i++) begin
				if (nb_acc[i]) begin
					stack_q[nb_slot[i][IdxW-1:0]] <= nb_cell[i];
				end
			end
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || drain) begin
			out_v_q  <= skid_v_q || acc;
			skid_v_q <= skid_v_q && acc;
		end else if (acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || drain) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (acc) begin
					skid_q <= res;
				end
			end else if (acc) begin
				out_q <= res;
			end
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_q.dropped, out_q.col, out_q.row};
	assign m_tuser  = out_q.status;

endmodule
`default_nettype wire
